// File: src/vts_pkg.sv
// Shared constants, types and the arctangent table for the velocity to
// speed and heading converter. No dependencies.
package vts_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_TABLE_LEN    = 24;
	localparam int N_ITER = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ?
		ATAN_TABLE_LEN : CORDIC_ITERATIONS;
	localparam int ITER_W     = (N_ITER > 1) ? $clog2(N_ITER) : 1;
	localparam int ATAN_IDX_W = 5;

	localparam int VEL_W      = 16;
	localparam int MAG_W      = 16;
	localparam int HEAD_W     = 15;
	localparam int EXTRA_FRAC = 8;

	// datapath: Q8.16 components with headroom for the CORDIC gain
	localparam int DP_W   = 27;
	localparam int Z_W    = 24;
	localparam int TOT_W  = 26;
	localparam int GAIN_W = 16;
	localparam int PROD_W = DP_W - 1 + GAIN_W;
	localparam int MAG_SHIFT = 16 + EXTRA_FRAC;

	localparam logic [GAIN_W-1:0] INV_GAIN  = 16'd39797;
	localparam logic [TOT_W-1:0]  FULL_Q16  = TOT_W'(360 * 65536);
	localparam logic [TOT_W-1:0]  HALF_Q16  = TOT_W'(180 * 65536);
	localparam logic [TOT_W-1:0]  HEAD_RND  = TOT_W'(512);
	localparam logic [PROD_W-1:0] MAG_RND   = PROD_W'(1) << (MAG_SHIFT - 1);
	localparam logic [MAG_W-1:0]  MAG_MAX   = '1;

	localparam logic [HEAD_W:0]   HEADING_FULL = (HEAD_W + 1)'(360 * 64);
	localparam logic [HEAD_W-1:0] HEADING_90   = HEAD_W'(90 * 64);
	localparam logic [HEAD_W-1:0] HEADING_270  = HEAD_W'(270 * 64);

	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic [MAG_W-1:0]        mag_t;
	typedef logic [HEAD_W-1:0]       head_t;
	typedef logic signed [DP_W-1:0]  dp_t;
	typedef logic signed [Z_W-1:0]   ang_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cord_sts_t;

	// atan(2^-i) in 1/65536 degree
	function automatic ang_t atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		ang_t a;
		case (idx)
			5'd0:    a = Z_W'(2949120);
			5'd1:    a = Z_W'(1740967);
			5'd2:    a = Z_W'(919879);
			5'd3:    a = Z_W'(466945);
			5'd4:    a = Z_W'(234379);
			5'd5:    a = Z_W'(117304);
			5'd6:    a = Z_W'(58666);
			5'd7:    a = Z_W'(29335);
			5'd8:    a = Z_W'(14668);
			5'd9:    a = Z_W'(7334);
			5'd10:   a = Z_W'(3667);
			5'd11:   a = Z_W'(1833);
			5'd12:   a = Z_W'(917);
			5'd13:   a = Z_W'(458);
			5'd14:   a = Z_W'(229);
			5'd15:   a = Z_W'(115);
			5'd16:   a = Z_W'(57);
			5'd17:   a = Z_W'(29);
			5'd18:   a = Z_W'(14);
			5'd19:   a = Z_W'(7);
			5'd20:   a = Z_W'(4);
			5'd21:   a = Z_W'(2);
			5'd22:   a = Z_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: src/vts_vel_if.sv
// Input channel: velocity components with valid/ready handshake.
// Depends on vts_pkg.
interface vts_vel_if import vts_pkg::*; ();
	logic valid;
	logic ready;
	vel_t horizontal_velocity;
	vel_t vertical_velocity;

	modport source (output valid, horizontal_velocity, vertical_velocity, input ready);
	modport sink   (input valid, horizontal_velocity, vertical_velocity, output ready);
endinterface

// File: src/vts_polar_if.sv
// Output channel: speed, heading and hold flag with valid/ready handshake.
// Depends on vts_pkg.
interface vts_polar_if import vts_pkg::*; ();
	logic  valid;
	logic  ready;
	mag_t  speed_magnitude;
	head_t heading_angle;
	logic  heading_held;

	modport source (output valid, speed_magnitude, heading_angle, heading_held,
		input ready);
	modport sink   (input valid, speed_magnitude, heading_angle, heading_held,
		output ready);
endinterface

// File: src/vts_cordic.sv
// Iterative CORDIC in vectoring mode: one shift-add rotation per cycle.
// Depends on vts_pkg.
module vts_cordic import vts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  vel_t      hx,
	input  vel_t      vy,
	output cord_sts_t sts,
	output dp_t       x,
	output ang_t      z
);

	dp_t               x_q, y_q;
	ang_t              z_q;
	logic [ITER_W-1:0] i_q;
	logic              busy_q, done_q;

	dp_t  hx_ext, vy_ext, x0, y0, xs, ys;
	ang_t a;
	logic last;

	always_comb begin
		hx_ext = DP_W'(hx);
		vy_ext = DP_W'(vy);
		// fold the left half plane into the right one
		if (hx[VEL_W-1]) begin
			x0 = (-hx_ext) <<< EXTRA_FRAC;
			y0 = (-vy_ext) <<< EXTRA_FRAC;
		end else begin
			x0 = hx_ext <<< EXTRA_FRAC;
			y0 = vy_ext <<< EXTRA_FRAC;
		end
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		a    = atan_q16(ATAN_IDX_W'(i_q));
		last = (i_q == ITER_W'(N_ITER - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[DP_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign x        = x_q;
	assign z        = z_q;

endmodule

// File: src/vts_post.sv
// Gain removal and heading wrap after the CORDIC: one registered multiply
// and wrap, then rounding and saturation. Depends on vts_pkg.
module vts_post import vts_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  logic  left_half,
	input  dp_t   x,
	input  ang_t  z,
	output mag_t  mag,
	output head_t heading
);

	logic [PROD_W-1:0] prod_q;
	logic [TOT_W-1:0]  tot_q;

	logic [DP_W-2:0]   x_pos;
	logic [PROD_W-1:0] prod_d;
	logic [TOT_W-1:0]  tot_raw, tot_d;
	logic [PROD_W-1:0] mag_sum;
	logic [PROD_W-MAG_SHIFT-1:0] mag_full;
	logic [TOT_W-1:0]  head_sum;
	logic [HEAD_W:0]   head_full;

	always_comb begin
		x_pos   = x[DP_W-1] ? '0 : x[DP_W-2:0];
		prod_d  = PROD_W'(x_pos) * PROD_W'(INV_GAIN);
		tot_raw = TOT_W'(z) + (left_half ? HALF_Q16 : '0);
		// wrap into [0, 360) degrees
		if (tot_raw[TOT_W-1])
			tot_d = tot_raw + FULL_Q16;
		else if (tot_raw >= FULL_Q16)
			tot_d = tot_raw - FULL_Q16;
		else
			tot_d = tot_raw;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod_d;
			tot_q  <= tot_d;
		end
	end

	always_comb begin
		mag_sum  = prod_q + MAG_RND;
		mag_full = mag_sum[PROD_W-1:MAG_SHIFT];
		mag      = (mag_full > (PROD_W-MAG_SHIFT)'(MAG_MAX)) ? MAG_MAX : mag_full[MAG_W-1:0];
		head_sum  = tot_q + HEAD_RND;
		head_full = head_sum[HEAD_W+10:10];
		if (head_full >= HEADING_FULL)
			head_full = head_full - HEADING_FULL;
		heading = head_full[HEAD_W-1:0];
	end

endmodule

// File: src/velocity_to_speed_and_heading_top.sv
// Velocity to speed and heading converter, top level.
// Depends on vts_pkg, vts_vel_if, vts_polar_if, vts_cordic and vts_post.
//
// vel (sink) takes signed Q8.8 horizontal and vertical velocity components.
// polar (source) gives for each item one result: speed in unsigned Q8.8,
// heading in 1/64 degree (0 to 23039) and a flag set when a zero vector
// kept the previous heading.
// One item is worked at a time; vel.ready is high only while idle.
// A nonzero vector passes one rotation per cycle through the single
// shift-add CORDIC unit, then the registered gain multiply and heading
// wrap, then rounding into the output register. A zero vector goes
// straight to the output register.
// The next item is taken as soon as its result is in the output register,
// even while the receiver has not taken it; a finished item waits in the
// last step until the output register frees.
// Reset clears the handshakes and sets the remembered heading to 0.
module velocity_to_speed_and_heading_top import vts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	vts_vel_if.sink            vel,
	vts_polar_if.source        polar
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic       zero_q, hzero_q, vpos_q, left_q;
	head_t      last_heading_q;
	mag_t       mag_q;
	head_t      head_q;
	logic       held_q, out_valid_q;

	logic      in_xfer, is_zero, out_write;
	cord_sts_t cord_sts;
	dp_t       cord_x;
	ang_t      cord_z;
	mag_t      post_mag;
	head_t     post_head;
	head_t     new_head;

	assign in_xfer = vel.valid && vel.ready;
	assign is_zero = (vel.horizontal_velocity == '0) && (vel.vertical_velocity == '0);
	assign out_write = (state_q == S_OUT) && (!out_valid_q || polar.ready);

	vts_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer && !is_zero),
		.hx     (vel.horizontal_velocity),
		.vy     (vel.vertical_velocity),
		.sts    (cord_sts),
		.x      (cord_x),
		.z      (cord_z)
	);

	vts_post u_post (
		.clk       (clk),
		.load      (cord_sts.done),
		.left_half (left_q),
		.x         (cord_x),
		.z         (cord_z),
		.mag       (post_mag),
		.heading   (post_head)
	);

	always_comb begin
		if (hzero_q)
			new_head = vpos_q ? HEADING_90 : HEADING_270;
		else
			new_head = post_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid_q    <= 1'b0;
			last_heading_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer)
						state_q <= is_zero ? S_OUT : S_RUN;
				end
				S_RUN: begin
					if (cord_sts.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_write)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (out_write) begin
				out_valid_q <= 1'b1;
				if (!zero_q)
					last_heading_q <= new_head;
			end else if (polar.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			zero_q  <= is_zero;
			hzero_q <= (vel.horizontal_velocity == '0);
			vpos_q  <= !vel.vertical_velocity[VEL_W-1];
			left_q  <= vel.horizontal_velocity[VEL_W-1];
		end
		if (out_write) begin
			// hold the previous heading for a zero vector
			if (zero_q) begin
				mag_q  <= '0;
				head_q <= last_heading_q;
				held_q <= 1'b1;
			end else begin
				mag_q  <= post_mag;
				head_q <= new_head;
				held_q <= 1'b0;
			end
		end
	end

	assign vel.ready             = (state_q == S_IDLE);
	assign polar.valid           = out_valid_q;
	assign polar.speed_magnitude = mag_q;
	assign polar.heading_angle   = head_q;
	assign polar.heading_held    = held_q;

endmodule
